// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the clock while out of reset.
`define UOI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock, reset included.
`define UOI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hw/rtl/uoi_pkg.sv
// Types, constants and lookup tables of the odometry integrator.
package uoi_pkg;

    localparam int MUL_AW = 40;
    localparam int MUL_BW = 28;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int CW     = 44;
    localparam int ZW     = 34;
    localparam int DIV_W  = 44;
    localparam int POS_W  = 32;

    localparam logic [31:0] ANGLE_PER_RAD = 32'd683565276;
    localparam logic [31:0] INV_GAIN      = 32'd2608131496;
    localparam logic [5:0]  DIV_A2        = 6'd6;
    localparam logic [5:0]  DIV_A3        = 6'd24;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_LOAD_GT   = 2'd1,
        CMD_LOAD_BOTH = 2'd2,
        CMD_NOP       = 2'd3
    } cmd_code_t;

    typedef enum logic [3:0] {
        OP_S     = 4'd0,
        OP_A     = 4'd1,
        OP_SQ    = 4'd2,
        OP_CUBE  = 4'd3,
        OP_DX    = 4'd4,
        OP_DY    = 4'd5,
        OP_TH_LO = 4'd6,
        OP_TH_HI = 4'd7,
        OP_G_LO  = 4'd8,
        OP_G_HI  = 4'd9
    } op_t;

    typedef struct packed {
        logic       capture;
        logic       load_gt;
        logic       load_odo;
        logic       mul_en;
        logic       wb_en;
        op_t        op;
        logic       div_start;
        logic       div_sel;
        logic       cordic_init;
        logic       cordic_step;
        logic [4:0] iter;
        logic [1:0] gsel;
        logic       head_upd;
        logic       publish;
    } uoi_cmd_t;

    typedef struct packed {
        logic div_done;
    } uoi_stat_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051D;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2E;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000002;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/uoi_div.sv
// Divider by a small constant, four quotient bits per cycle, truncating toward zero.
module uoi_div
    import uoi_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    sel,
    input  logic signed [DIV_W-1:0] dividend,
    output logic                    done,
    output logic signed [DIV_W-1:0] quotient
);

    localparam int DIGIT = 4;
    localparam int NSTEP = DIV_W / DIGIT;
    localparam int CNT_W = $clog2(NSTEP + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] work_reg;
    logic [DIV_W-1:0] work_next;
    logic [4:0]       rem_reg;
    logic [4:0]       rem_next;
    logic             neg_reg;
    logic             sel_reg;

    always_comb begin
        logic [5:0]       d;
        logic [5:0]       t;
        logic [4:0]       r;
        logic [DIV_W-1:0] w;
        d = sel_reg ? DIV_A3 : DIV_A2;
        r = rem_reg;
        w = work_reg;
        for (int k = 0; k < DIGIT; k++) begin
            t = {r, w[DIV_W-1]};
            w = {w[DIV_W-2:0], 1'b0};
            if (t >= d) begin
                t = t - d;
                w[0] = 1'b1;
            end
            r = t[4:0];
        end
        work_next = w;
        rem_next  = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NSTEP);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
            neg_reg  <= dividend[DIV_W-1];
            sel_reg  <= sel;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? DIV_W'(-signed'(work_reg)) : signed'(work_reg);

endmodule

// File: hw/rtl/uoi_dp.sv
// Datapath: shared multiplier, divider, two CORDIC lanes and the pose registers.
module uoi_dp
    import uoi_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  uoi_cmd_t       cmd,
    output uoi_stat_t      stat,
    input  logic [159:0]   in_data,
    output logic [191:0]   out_data
);

    logic signed [23:0]        v_reg;
    logic signed [23:0]        w_reg;
    logic [15:0]               dt_reg;
    logic [POS_W-1:0]          ldx_reg;
    logic [POS_W-1:0]          ldy_reg;
    logic [POS_W-1:0]          ldh_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [23:0]        s16_reg;
    logic signed [39:0]        a_reg;
    logic signed [35:0]        a2_reg;
    logic signed [43:0]        a3_reg;
    logic signed [MUL_AW-1:0]  fx_reg;
    logic signed [MUL_AW-1:0]  fy_reg;
    logic signed [CW-1:0]      dx_reg;
    logic signed [CW-1:0]      dy_reg;
    logic [63:0]               acc_reg;
    logic [POS_W-1:0]          dth_reg;
    logic signed [CW-1:0]      cx_reg [2];
    logic signed [CW-1:0]      cy_reg [2];
    logic signed [ZW-1:0]      cz_reg [2];
    logic signed [CW-1:0]      cx_next [2];
    logic signed [CW-1:0]      cy_next [2];
    logic signed [ZW-1:0]      cz_next [2];
    logic [POS_W-1:0]          px_reg [2];
    logic [POS_W-1:0]          py_reg [2];
    logic [POS_W-1:0]          ph_reg [2];
    logic [191:0]              out_reg;

    logic signed [27:0]        a20;
    logic signed [MUL_AW-1:0]  mul_a;
    logic signed [MUL_BW-1:0]  mul_b;
    logic signed [CW-1:0]      g_val;
    logic [63:0]               th_sum;
    logic [63:0]               g_sum;
    logic                      div_done;
    logic signed [DIV_W-1:0]   div_q;
    logic signed [DIV_W-1:0]   div_in;
    logic signed [DIV_W-1:0]   fx_wide;
    logic signed [DIV_W-1:0]   fy_wide;

    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd2147483648);

    assign a20    = a_reg[39:12];
    assign g_val  = cmd.gsel[0] ? cy_reg[cmd.gsel[1]] : cx_reg[cmd.gsel[1]];
    assign th_sum = acc_reg + (prod_reg[63:0] << 20);
    assign g_sum  = acc_reg + (prod_reg[63:0] << 22);
    assign div_in = cmd.div_sel ? a3_reg : DIV_W'(a2_reg);
    assign fx_wide = DIV_W'(64'sd1048576) - div_q;
    assign fy_wide = DIV_W'(a20 >>> 1) - div_q;

    uoi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .sel      (cmd.div_sel),
        .dividend (div_in),
        .done     (div_done),
        .quotient (div_q)
    );

    assign stat.div_done = div_done;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_S: begin
                mul_a = MUL_AW'(v_reg);
                mul_b = {12'd0, dt_reg};
            end
            OP_A: begin
                mul_a = MUL_AW'(w_reg);
                mul_b = {12'd0, dt_reg};
            end
            OP_SQ: begin
                mul_a = MUL_AW'(a20);
                mul_b = a20;
            end
            OP_CUBE: begin
                mul_a = MUL_AW'(a2_reg);
                mul_b = a20;
            end
            OP_DX: begin
                mul_a = fx_reg;
                mul_b = MUL_BW'(s16_reg);
            end
            OP_DY: begin
                mul_a = fy_reg;
                mul_b = MUL_BW'(s16_reg);
            end
            OP_TH_LO: begin
                mul_a = {8'd0, ANGLE_PER_RAD};
                mul_b = {8'd0, a_reg[19:0]};
            end
            OP_TH_HI: begin
                mul_a = {8'd0, ANGLE_PER_RAD};
                mul_b = MUL_BW'(signed'(a_reg[39:20]));
            end
            OP_G_LO: begin
                mul_a = {8'd0, INV_GAIN};
                mul_b = {6'd0, g_val[21:0]};
            end
            OP_G_HI: begin
                mul_a = {8'd0, INV_GAIN};
                mul_b = MUL_BW'(signed'(g_val[43:22]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            logic signed [ZW-1:0] z0;
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            logic signed [ZW-1:0] at;
            z0 = {{(ZW - POS_W){ph_reg[l][POS_W-1]}}, ph_reg[l]};
            xs = cx_reg[l] >>> cmd.iter;
            ys = cy_reg[l] >>> cmd.iter;
            at = ZW'(atan_lut(cmd.iter));
            cx_next[l] = cx_reg[l];
            cy_next[l] = cy_reg[l];
            cz_next[l] = cz_reg[l];
            if (cmd.cordic_init) begin
                if (z0 > QUARTER) begin
                    cx_next[l] = -dx_reg;
                    cy_next[l] = -dy_reg;
                    cz_next[l] = z0 - HALF;
                end else if (z0 < -QUARTER) begin
                    cx_next[l] = -dx_reg;
                    cy_next[l] = -dy_reg;
                    cz_next[l] = z0 + HALF;
                end else begin
                    cx_next[l] = dx_reg;
                    cy_next[l] = dy_reg;
                    cz_next[l] = z0;
                end
            end else if (cmd.cordic_step) begin
                if (!cz_reg[l][ZW-1]) begin
                    cx_next[l] = cx_reg[l] - ys;
                    cy_next[l] = cy_reg[l] + xs;
                    cz_next[l] = cz_reg[l] - at;
                end else begin
                    cx_next[l] = cx_reg[l] + ys;
                    cy_next[l] = cy_reg[l] - xs;
                    cz_next[l] = cz_reg[l] + at;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            v_reg   <= in_data[23:0];
            w_reg   <= in_data[47:24];
            dt_reg  <= in_data[63:48];
            ldx_reg <= in_data[95:64];
            ldy_reg <= in_data[127:96];
            ldh_reg <= in_data[159:128];
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.wb_en) begin
            case (cmd.op)
                OP_S:     s16_reg <= prod_reg[39:16];
                OP_A:     a_reg   <= prod_reg[39:0];
                OP_SQ:    a2_reg  <= prod_reg[55:20];
                OP_CUBE:  a3_reg  <= prod_reg[63:20];
                OP_DX:    dx_reg  <= prod_reg[63:20];
                OP_DY:    dy_reg  <= prod_reg[63:20];
                OP_TH_LO: acc_reg <= prod_reg[63:0];
                OP_G_LO:  acc_reg <= prod_reg[63:0];
                OP_TH_HI: dth_reg <= th_sum[63:32];
                default: ;
            endcase
        end
        if (div_done) begin
            if (cmd.div_sel) begin
                fy_reg <= fy_wide[MUL_AW-1:0];
            end else begin
                fx_reg <= fx_wide[MUL_AW-1:0];
            end
        end
        for (int l = 0; l < 2; l++) begin
            cx_reg[l] <= cx_next[l];
            cy_reg[l] <= cy_next[l];
            cz_reg[l] <= cz_next[l];
        end
        if (cmd.publish) begin
            out_reg <= {ph_reg[1], py_reg[1], px_reg[1], ph_reg[0], py_reg[0], px_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < 2; l++) begin
                px_reg[l] <= '0;
                py_reg[l] <= '0;
                ph_reg[l] <= '0;
            end
        end else begin
            if (cmd.load_odo) begin
                px_reg[0] <= ldx_reg;
                py_reg[0] <= ldy_reg;
                ph_reg[0] <= ldh_reg;
            end
            if (cmd.load_gt) begin
                px_reg[1] <= ldx_reg;
                py_reg[1] <= ldy_reg;
                ph_reg[1] <= ldh_reg;
            end
            if (cmd.wb_en && cmd.op == OP_G_HI) begin
                if (cmd.gsel[0]) begin
                    py_reg[cmd.gsel[1]] <= py_reg[cmd.gsel[1]] + g_sum[63:32];
                end else begin
                    px_reg[cmd.gsel[1]] <= px_reg[cmd.gsel[1]] + g_sum[63:32];
                end
            end
            if (cmd.head_upd) begin
                ph_reg[0] <= ph_reg[0] + dth_reg;
                ph_reg[1] <= ph_reg[1] + dth_reg;
            end
        end
    end

    assign out_data = out_reg;

endmodule

// File: hw/rtl/uoi_ctrl.sv
// Controller: sequences multiplies, divisions, CORDIC steps and the result handshake.
module uoi_ctrl
    import uoi_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [1:0] s_cmd,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  uoi_stat_t stat,
    output uoi_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LOAD   = 10'b0000000010,
        S_MUL    = 10'b0000000100,
        S_WB     = 10'b0000001000,
        S_DIV_GO = 10'b0000010000,
        S_DIV    = 10'b0000100000,
        S_CINIT  = 10'b0001000000,
        S_CORDIC = 10'b0010000000,
        S_HEAD   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t    state_reg, state_next;
    op_t       op_reg, op_next;
    logic [4:0] iter_reg, iter_next;
    logic [1:0] gsel_reg, gsel_next;
    logic [1:0] code_reg, code_next;
    logic      dsel_reg, dsel_next;
    logic      valid_reg, valid_next;
    logic      accept;
    logic      publish;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign publish  = (state_reg == S_DONE) && (!valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        iter_next  = iter_reg;
        gsel_next  = gsel_reg;
        code_next  = code_reg;
        dsel_next  = dsel_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    code_next = s_cmd;
                    if (s_cmd == CMD_TICK) begin
                        op_next    = OP_S;
                        state_next = S_MUL;
                    end else begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:   state_next = S_DONE;
            S_MUL:    state_next = S_WB;
            S_WB: begin
                state_next = S_MUL;
                case (op_reg)
                    OP_S:     op_next = OP_A;
                    OP_A:     op_next = OP_SQ;
                    OP_SQ: begin
                        dsel_next  = 1'b0;
                        state_next = S_DIV_GO;
                    end
                    OP_CUBE: begin
                        dsel_next  = 1'b1;
                        state_next = S_DIV_GO;
                    end
                    OP_DX:    op_next = OP_DY;
                    OP_DY:    op_next = OP_TH_LO;
                    OP_TH_LO: op_next = OP_TH_HI;
                    OP_TH_HI: state_next = S_CINIT;
                    OP_G_LO:  op_next = OP_G_HI;
                    OP_G_HI: begin
                        if (gsel_reg == 2'd3) begin
                            state_next = S_HEAD;
                        end else begin
                            gsel_next = gsel_reg + 2'd1;
                            op_next   = OP_G_LO;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DIV_GO: state_next = S_DIV;
            S_DIV: begin
                if (stat.div_done) begin
                    op_next    = dsel_reg ? OP_DX : OP_CUBE;
                    state_next = S_MUL;
                end
            end
            S_CINIT: begin
                iter_next  = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC: begin
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(CORDIC_STEPS - 1)) begin
                    op_next    = OP_G_LO;
                    gsel_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_HEAD:   state_next = S_DONE;
            S_DONE: begin
                if (publish) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    assign valid_next = publish ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_S;
            iter_reg  <= '0;
            gsel_reg  <= '0;
            code_reg  <= CMD_NOP;
            dsel_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            iter_reg  <= iter_next;
            gsel_reg  <= gsel_next;
            code_reg  <= code_next;
            dsel_reg  <= dsel_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

    always_comb begin
        cmd             = '0;
        cmd.capture     = accept;
        cmd.load_gt     = (state_reg == S_LOAD)
                          && (code_reg == CMD_LOAD_GT || code_reg == CMD_LOAD_BOTH);
        cmd.load_odo    = (state_reg == S_LOAD) && (code_reg == CMD_LOAD_BOTH);
        cmd.mul_en      = (state_reg == S_MUL);
        cmd.wb_en       = (state_reg == S_WB);
        cmd.op          = op_reg;
        cmd.div_start   = (state_reg == S_DIV_GO);
        cmd.div_sel     = dsel_reg;
        cmd.cordic_init = (state_reg == S_CINIT);
        cmd.cordic_step = (state_reg == S_CORDIC);
        cmd.iter        = iter_reg;
        cmd.gsel        = gsel_reg;
        cmd.head_upd    = (state_reg == S_HEAD);
        cmd.publish     = publish;
    end

endmodule

// File: hw/rtl/unicycle_odometry_integrator_unit.sv
// A tick item runs the shared 40x28 multiplier sequence, the constant divider (four bits
// a cycle) and the CORDIC loop of one iteration a cycle for both poses. Load items and
// the unused command only pass through the load and done states. One item is in work at
// a time, so no item is taken until the last one has produced its result.
// The next item is taken while a result waits in the output register.
// Synchronous active-low reset clears both poses to zero and empties the output.
module unicycle_odometry_integrator_unit
    import uoi_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // cmd
    input  logic [159:0] s_tdata,   // speed, turn_rate, time_step, pose_x, pose_y, pose_heading
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata    // odom_x, odom_y, odom_heading, true_x, true_y, true_heading
);

    uoi_cmd_t  cmd;
    uoi_stat_t stat;

    uoi_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    uoi_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_tdata),
        .out_data (m_tdata)
    );

endmodule

// File: hw/rtl/uoi_chk.sv
// Port-level checker for the odometry integrator, bound to the top level.
`include "assert_macros.svh"

module uoi_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic [159:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);

    `UOI_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `UOI_ASSERT_ALWAYS(a_rst_empty, !aresetn |=> !m_tvalid, "result valid after reset")
    `UOI_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "item accepted while busy")
    `UOI_ASSERT(a_no_early_result, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "result appeared too early")

endmodule

bind unicycle_odometry_integrator_unit uoi_chk u_chk (.*);

// File: verif/tb_unicycle_odometry_integrator_unit.sv
// Testbench for the unicycle odometry integrator: table of directed items, then random traffic.
`timescale 1ns / 100ps

module tb_unicycle_odometry_integrator_unit;
    import uoi_pkg::*;

    typedef struct packed {
        logic [31:0] odom_x;
        logic [31:0] odom_y;
        logic [31:0] odom_heading;
        logic [31:0] true_x;
        logic [31:0] true_y;
        logic [31:0] true_heading;
    } pose_pair_t;

    typedef struct {
        cmd_code_t   cmd;
        logic [23:0] speed;
        logic [23:0] rate;
        logic [15:0] dt;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] ph;
        bit          typed;
        pose_pair_t  want;
    } stim_row_t;

    localparam int STEPS       = 24;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PRESSURE_AT = 500;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;

    pose_pair_t pose_state;
    pose_pair_t pending_poses[$];
    stim_row_t  stim_table[$];
    int         error_count = 0;
    int         accepted_items = 0;
    int         tick_count = 0;
    int         load_count = 0;
    int         result_count = 0;
    bit         stimulus_done = 1'b0;

    logic [31:0] atan_steps[32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    unicycle_odometry_integrator_unit #(.CORDIC_STEPS(STEPS)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("status: fail");
        $finish;
    end

    // floor(x * c / 2^32)
    function automatic longint scale_q32(longint x, longint c);
        longint hi;
        longint lo;
        hi = x >>> 16;
        lo = ((x & 64'hFFFF) * c) >> 16;
        return (hi * c + lo) >>> 16;
    endfunction

    function automatic void rotate_into(input logic [31:0] heading, input longint dx,
                                        input longint dy, inout logic [31:0] px,
                                        inout logic [31:0] py);
        longint x;
        longint y;
        longint z;
        longint t;
        x = dx;
        y = dy;
        z = longint'($signed(heading));
        if (z > (64'sd1 <<< 30)) begin
            x = -x; y = -y; z = z - (64'sd1 <<< 31);
        end else if (z < -(64'sd1 <<< 30)) begin
            x = -x; y = -y; z = z + (64'sd1 <<< 31);
        end
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(atan_steps[i]);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(atan_steps[i]);
            end
            x = t;
        end
        x = scale_q32(x, longint'(INV_GAIN));
        y = scale_q32(y, longint'(INV_GAIN));
        px = px + x[31:0];
        py = py + y[31:0];
    endfunction

    function automatic void advance_poses(cmd_code_t cmd, logic [159:0] d);
        longint v, w, dt, s16, a, a20, a2, a3, fx, fy, dx, dy, dth;
        if (cmd == CMD_TICK) begin
            v   = longint'($signed(d[23:0]));
            w   = longint'($signed(d[47:24]));
            dt  = longint'(d[63:48]);
            s16 = (v * dt) >>> 16;
            a   = w * dt;
            a20 = a >>> 12;
            a2  = (a20 * a20) >>> 20;
            a3  = (a2 * a20) >>> 20;
            fx  = (64'sd1 <<< 20) - a2 / 6;
            fy  = (a20 >>> 1) - a3 / 24;
            dx  = (s16 * fx) >>> 20;
            dy  = (s16 * fy) >>> 20;
            dth = scale_q32(a, longint'(ANGLE_PER_RAD));
            rotate_into(pose_state.odom_heading, dx, dy, pose_state.odom_x, pose_state.odom_y);
            rotate_into(pose_state.true_heading, dx, dy, pose_state.true_x, pose_state.true_y);
            pose_state.odom_heading = pose_state.odom_heading + dth[31:0];
            pose_state.true_heading = pose_state.true_heading + dth[31:0];
        end else if (cmd == CMD_LOAD_GT || cmd == CMD_LOAD_BOTH) begin
            pose_state.true_x       = d[95:64];
            pose_state.true_y       = d[127:96];
            pose_state.true_heading = d[159:128];
            if (cmd == CMD_LOAD_BOTH) begin
                pose_state.odom_x       = d[95:64];
                pose_state.odom_y       = d[127:96];
                pose_state.odom_heading = d[159:128];
            end
        end
    endfunction

    function automatic void add_row(cmd_code_t cmd, logic [23:0] speed, logic [23:0] rate,
                                    logic [15:0] dt, logic [31:0] px, logic [31:0] py,
                                    logic [31:0] ph, bit typed = 1'b0,
                                    pose_pair_t want = '0);
        stim_row_t r;
        r.cmd = cmd; r.speed = speed; r.rate = rate; r.dt = dt;
        r.px = px; r.py = py; r.ph = ph; r.typed = typed; r.want = want;
        stim_table.push_back(r);
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t r;
        int p;
        int mode;
        p = $urandom_range(99);
        r.typed = 1'b0;
        r.want = '0;
        r.cmd = (p < 78) ? CMD_TICK : (p < 88) ? CMD_LOAD_GT : (p < 97) ? CMD_LOAD_BOTH : CMD_NOP;
        mode = $urandom_range(3);
        r.speed = 24'($urandom);
        r.rate  = 24'($urandom);
        r.dt    = 16'($urandom);
        if (mode != 0) begin
            r.speed = 24'($signed($urandom_range(1 << 18)) - (1 << 17));
            r.rate  = 24'($signed($urandom_range(1 << 19)) - (1 << 18));
            r.dt    = 16'($urandom_range(8192));
        end
        r.px = $urandom;
        r.py = $urandom;
        r.ph = $urandom;
        if (mode == 1) begin
            r.ph = 32'h40000000 + $urandom_range(4) - 2;
        end else if (mode == 2) begin
            r.ph = 32'hC0000000 + $urandom_range(4) - 2;
        end
        return r;
    endfunction

    task automatic send_row(input stim_row_t r);
        logic [159:0] d;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        d = {r.ph, r.py, r.px, r.dt, r.rate, r.speed};
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        advance_poses(r.cmd, d);
        pending_poses.push_back(r.typed ? r.want : pose_state);
        accepted_items++;
        if (r.cmd == CMD_TICK) tick_count++;
        else load_count++;
    endtask

    initial begin
        pose_pair_t w;
        stim_row_t r;
        pose_state = '0;
        add_row(CMD_NOP, 24'h7FFFFF, 24'h800000, 16'hFFFF, 32'hFFFFFFFF, 32'h1, 32'h2, 1'b1, '0);
        add_row(CMD_TICK, 24'h7FFFFF, 24'h7FFFFF, 16'h0000, 32'h5, 32'h6, 32'h7, 1'b1, '0);
        w = '{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
              32'hFFFFFFFF};
        add_row(CMD_LOAD_BOTH, 24'h0, 24'h0, 16'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                1'b1, w);
        w = '{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h40000000};
        add_row(CMD_LOAD_GT, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h40000000, 1'b1, w);
        add_row(CMD_TICK, 24'h7FFFFF, 24'h000000, 16'hFFFF, 32'h0, 32'h0, 32'h0);
        add_row(CMD_TICK, 24'h800000, 24'h800000, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'h0);
        add_row(CMD_TICK, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 32'h0, 32'hFFFFFFFF, 32'h0);
        add_row(CMD_TICK, 24'h7FFFFF, 24'h800000, 16'h0001, 32'h0, 32'h0, 32'h0);
        w = '{32'h0, 32'h0, 32'h40000000, 32'h0, 32'h0, 32'h40000000};
        add_row(CMD_LOAD_BOTH, 24'h0, 24'h0, 16'h0, 32'h0, 32'h0, 32'h40000000, 1'b1, w);
        add_row(CMD_TICK, 24'h010000, 24'h000000, 16'h8000, 32'h0, 32'h0, 32'h0);
        w = '{32'h0, 32'h0, 32'hC0000000, 32'h0, 32'h0, 32'hC0000000};
        add_row(CMD_LOAD_BOTH, 24'h0, 24'h0, 16'h0, 32'h0, 32'h0, 32'hC0000000, 1'b1, w);
        add_row(CMD_TICK, 24'h020000, 24'h008000, 16'h4000, 32'h0, 32'h0, 32'h0);
        add_row(CMD_LOAD_BOTH, 24'h0, 24'h0, 16'h0, 32'h0, 32'h0, 32'h40000001);
        add_row(CMD_TICK, 24'h030000, 24'hFF8000, 16'h2000, 32'h0, 32'h0, 32'h0);
        add_row(CMD_LOAD_BOTH, 24'h0, 24'h0, 16'h0, 32'h7FFF0000, 32'h80010000, 32'h80000000);
        add_row(CMD_TICK, 24'h7FFFFF, 24'h123456, 16'hFFFF, 32'h0, 32'h0, 32'h0);
        add_row(CMD_LOAD_GT, 24'h0, 24'h0, 16'h0, 32'h00010000, 32'hFFFF0000, 32'hBFFFFFFF);
        add_row(CMD_TICK, 24'hFFFFFF, 24'h000001, 16'hFFFF, 32'h0, 32'h0, 32'h0);
        add_row(CMD_NOP, 24'h0, 24'h0, 16'h0, 32'h1, 32'h1, 32'h1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (stim_table[i]) send_row(stim_table[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = random_row();
            send_row(r);
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial begin
        int run;
        bit pressed;
        pressed = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!pressed && accepted_items >= PRESSURE_AT) begin
                pressed = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            run = pick_gap();
            if (run > 0) begin
                m_tready <= 1'b0;
                repeat (run) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        pose_pair_t got;
        pose_pair_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                   m_tdata[127:96], m_tdata[159:128], m_tdata[191:160]};
            result_count++;
            if (pending_poses.size() == 0) begin
                $error("result with no item pending: %h", m_tdata);
                error_count++;
            end else begin
                want = pending_poses.pop_front();
                if (got.odom_x !== want.odom_x) begin
                    $error("odom_x expected %h got %h", want.odom_x, got.odom_x);
                    error_count++;
                end
                if (got.odom_y !== want.odom_y) begin
                    $error("odom_y expected %h got %h", want.odom_y, got.odom_y);
                    error_count++;
                end
                if (got.odom_heading !== want.odom_heading) begin
                    $error("odom_heading expected %h got %h", want.odom_heading,
                           got.odom_heading);
                    error_count++;
                end
                if (got.true_x !== want.true_x) begin
                    $error("true_x expected %h got %h", want.true_x, got.true_x);
                    error_count++;
                end
                if (got.true_y !== want.true_y) begin
                    $error("true_y expected %h got %h", want.true_y, got.true_y);
                    error_count++;
                end
                if (got.true_heading !== want.true_heading) begin
                    $error("true_heading expected %h got %h", want.true_heading,
                           got.true_heading);
                    error_count++;
                end
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (pending_poses.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (pending_poses.size() != 0) begin
            $error("%0d results never arrived", pending_poses.size());
            error_count++;
        end
        $display("covered %0d items: %0d ticks, %0d pose loads or no-ops, %0d results checked",
                 accepted_items, tick_count, load_count, result_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
